@@ hw/rtl/aisa_pkg.sv @@
// Shared types and constants for the accumulator instruction-set core.
`default_nettype none

package aisa_pkg;

    localparam int DATA_W = 32;
    localparam int ADDR_W = 12;

    // Item kinds.
    localparam logic [1:0] KIND_WRITE = 2'd0;
    localparam logic [1:0] KIND_EXEC  = 2'd1;
    localparam logic [1:0] KIND_READ  = 2'd2;

    // Status codes.
    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_HALT    = 3'd1;
    localparam logic [2:0] ST_STOPPED = 3'd2;
    localparam logic [2:0] ST_BADOP   = 3'd3;
    localparam logic [2:0] ST_BADPC   = 3'd4;
    localparam logic [2:0] ST_BADADDR = 3'd5;

    // Opcodes.
    localparam logic [7:0] OP_LDC  = 8'd0;
    localparam logic [7:0] OP_ADC  = 8'd1;
    localparam logic [7:0] OP_LDL  = 8'd2;
    localparam logic [7:0] OP_STL  = 8'd3;
    localparam logic [7:0] OP_LDNL = 8'd4;
    localparam logic [7:0] OP_STNL = 8'd5;
    localparam logic [7:0] OP_ADD  = 8'd6;
    localparam logic [7:0] OP_SUB  = 8'd7;
    localparam logic [7:0] OP_SHL  = 8'd8;
    localparam logic [7:0] OP_SHR  = 8'd9;
    localparam logic [7:0] OP_ADJ  = 8'd10;
    localparam logic [7:0] OP_A2SP = 8'd11;
    localparam logic [7:0] OP_SP2A = 8'd12;
    localparam logic [7:0] OP_CALL = 8'd13;
    localparam logic [7:0] OP_RET  = 8'd14;
    localparam logic [7:0] OP_BRZ  = 8'd15;
    localparam logic [7:0] OP_BRLZ = 8'd16;
    localparam logic [7:0] OP_BR   = 8'd17;
    localparam logic [7:0] OP_HALT = 8'd18;

    typedef struct packed {
        logic [1:0]        kind;
        logic [ADDR_W-1:0] address;
        logic [DATA_W-1:0] data_word;
    } item_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] program_counter;
        logic signed [DATA_W-1:0] accumulator;
        logic signed [DATA_W-1:0] second_register;
        logic signed [DATA_W-1:0] stack_pointer;
        logic [DATA_W-1:0]        read_data;
        logic [7:0]               executed_opcode;
        logic [2:0]               status;
    } result_t;

    typedef struct packed {
        logic [DATA_W-1:0] pc;
        logic [DATA_W-1:0] a;
        logic [DATA_W-1:0] b;
        logic [DATA_W-1:0] sp;
    } arch_t;

    // Commands from the sequencer to the execute unit.
    typedef struct packed {
        logic commit_exec;
        logic commit_load;
        logic stop_pc;
    } exec_ctl_t;

    // Decode and status information back to the sequencer.
    typedef struct packed {
        logic              running;
        logic              pc_ok;
        logic              is_load;
        logic              is_store;
        logic              ea_ok;
        logic [DATA_W-1:0] ea;
        logic [7:0]        opcode;
        logic [DATA_W-1:0] store_data;
        logic [2:0]        status;
    } exec_info_t;

endpackage

`default_nettype wire

@@ hw/rtl/accumulator_isa_core.sv @@
// Top level of the accumulator core: input buffer, sequencer and result register.
`default_nettype none

// Two-register accumulator processor with a private word memory of MEM_WORDS words.
// After reset the memory is cleared one word a cycle, so no item is taken before the
// pass ends. Each item then waits in the input buffer and is worked through a memory
// with one write port and one registered read port: a write is one memory write, a
// read issues the read and takes the registered data, an instruction is fetched, then
// executed or stored; ldl and ldnl read memory again. An item is taken while the
// previous one is still being worked or its result still waits in the output register.
module accumulator_isa_core #(
    parameter int MEM_WORDS = 4096
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              item_valid,
    output logic                   item_ready,
    input  wire aisa_pkg::item_t   item,
    output logic                   result_valid,
    input  wire logic              result_ready,
    output aisa_pkg::result_t      result
);

    localparam int AW = $clog2(MEM_WORDS);
    localparam logic [aisa_pkg::DATA_W-1:0] MemLimit = aisa_pkg::DATA_W'(MEM_WORDS);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_RDWAIT = 2'd1;
    localparam logic [1:0] S_FETCH  = 2'd2;
    localparam logic [1:0] S_LOAD   = 2'd3;

    logic [1:0]                  state_reg;
    logic [1:0]                  state_next;
    logic                        buf_valid_reg;
    logic                        buf_valid_next;
    aisa_pkg::item_t             buf_reg;
    logic [aisa_pkg::DATA_W-1:0] instr_reg;
    logic [aisa_pkg::DATA_W-1:0] instr_next;
    logic                        rd_ok_reg;
    logic                        rd_ok_next;
    logic                        res_valid_reg;
    logic                        res_valid_next;
    aisa_pkg::result_t           res_reg;
    aisa_pkg::result_t           res_next;

    logic                        pop;
    logic                        emit;
    logic [aisa_pkg::DATA_W-1:0] emit_rd;
    logic [7:0]                  emit_op;
    logic [2:0]                  emit_st;
    logic                        out_free;

    logic                        mem_wr_en;
    logic [AW-1:0]               mem_wr_addr;
    logic [aisa_pkg::DATA_W-1:0] mem_wr_data;
    logic                        mem_rd_en;
    logic [AW-1:0]               mem_rd_addr;
    logic [aisa_pkg::DATA_W-1:0] mem_rd_data;
    logic                        mem_busy;

    aisa_pkg::exec_ctl_t         ctl;
    aisa_pkg::arch_t             arch_next;
    aisa_pkg::exec_info_t        info;
    logic [aisa_pkg::DATA_W-1:0] exec_instr;

    logic [aisa_pkg::DATA_W-1:0] item_addr;
    logic                        item_addr_ok;

    aisa_mem #(
        .MEM_WORDS (MEM_WORDS)
    ) u_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data),
        .busy    (mem_busy)
    );

    aisa_exec #(
        .MEM_WORDS (MEM_WORDS)
    ) u_exec (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl),
        .instr     (exec_instr),
        .mem_word  (mem_rd_data),
        .arch_next (arch_next),
        .info      (info)
    );

    // During a load the read port carries the data word, so the instruction is held.
    assign exec_instr   = (state_reg == S_LOAD) ? instr_reg : mem_rd_data;
    assign item_addr    = aisa_pkg::DATA_W'(buf_reg.address);
    assign item_addr_ok = item_addr < MemLimit;
    assign out_free     = !res_valid_reg || result_ready;
    assign item_ready   = !buf_valid_reg && !mem_busy;

    always_comb
    begin
        state_next  = state_reg;
        instr_next  = instr_reg;
        rd_ok_next  = rd_ok_reg;
        pop         = 1'b0;
        emit        = 1'b0;
        emit_rd     = '0;
        emit_op     = '0;
        emit_st     = aisa_pkg::ST_OK;
        mem_wr_en   = 1'b0;
        mem_wr_addr = item_addr[AW-1:0];
        mem_wr_data = buf_reg.data_word;
        mem_rd_en   = 1'b0;
        mem_rd_addr = item_addr[AW-1:0];
        ctl         = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (buf_valid_reg)
                begin
                    unique case (buf_reg.kind)
                        aisa_pkg::KIND_WRITE:
                        begin
                            if (out_free)
                            begin
                                pop       = 1'b1;
                                emit      = 1'b1;
                                mem_wr_en = item_addr_ok;
                            end
                        end
                        aisa_pkg::KIND_READ:
                        begin
                            pop        = 1'b1;
                            mem_rd_en  = item_addr_ok;
                            rd_ok_next = item_addr_ok;
                            state_next = S_RDWAIT;
                        end
                        aisa_pkg::KIND_EXEC:
                        begin
                            if (!info.running)
                            begin
                                if (out_free)
                                begin
                                    pop     = 1'b1;
                                    emit    = 1'b1;
                                    emit_st = aisa_pkg::ST_STOPPED;
                                end
                            end
                            else if (!info.pc_ok)
                            begin
                                if (out_free)
                                begin
                                    pop         = 1'b1;
                                    emit        = 1'b1;
                                    ctl.stop_pc = 1'b1;
                                    emit_st     = info.status;
                                end
                            end
                            else
                            begin
                                pop         = 1'b1;
                                mem_rd_en   = 1'b1;
                                mem_rd_addr = arch_next.pc[AW-1:0];
                                state_next  = S_FETCH;
                            end
                        end
                        default:
                        begin
                            if (out_free)
                            begin
                                pop  = 1'b1;
                                emit = 1'b1;
                            end
                        end
                    endcase
                end
            end
            S_RDWAIT:
            begin
                if (out_free)
                begin
                    emit       = 1'b1;
                    emit_rd    = rd_ok_reg ? mem_rd_data : '0;
                    state_next = S_IDLE;
                end
            end
            S_FETCH:
            begin
                if (info.is_load && info.ea_ok)
                begin
                    mem_rd_en   = 1'b1;
                    mem_rd_addr = info.ea[AW-1:0];
                    instr_next  = mem_rd_data;
                    state_next  = S_LOAD;
                end
                else if (out_free)
                begin
                    ctl.commit_exec = 1'b1;
                    emit            = 1'b1;
                    emit_op         = info.opcode;
                    emit_st         = info.status;
                    mem_wr_en       = info.is_store && info.ea_ok;
                    mem_wr_addr     = info.ea[AW-1:0];
                    mem_wr_data     = info.store_data;
                    state_next      = S_IDLE;
                end
            end
            S_LOAD:
            begin
                if (out_free)
                begin
                    ctl.commit_load = 1'b1;
                    emit            = 1'b1;
                    emit_op         = info.opcode;
                    emit_st         = info.status;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        buf_valid_next = buf_valid_reg;
        if (pop)
        begin
            buf_valid_next = 1'b0;
        end
        if (item_valid && item_ready)
        begin
            buf_valid_next = 1'b1;
        end

        res_valid_next = res_valid_reg;
        res_next       = res_reg;
        if (emit)
        begin
            res_valid_next           = 1'b1;
            res_next.program_counter = $signed(arch_next.pc);
            res_next.accumulator     = $signed(arch_next.a);
            res_next.second_register = $signed(arch_next.b);
            res_next.stack_pointer   = $signed(arch_next.sp);
            res_next.read_data       = emit_rd;
            res_next.executed_opcode = emit_op;
            res_next.status          = emit_st;
        end
        else if (result_ready)
        begin
            res_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            buf_valid_reg <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            buf_valid_reg <= buf_valid_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_valid && item_ready)
        begin
            buf_reg <= item;
        end
        instr_reg <= instr_next;
        rd_ok_reg <= rd_ok_next;
        res_reg   <= res_next;
    end

    assign result_valid = res_valid_reg;
    assign result       = res_reg;

endmodule

`default_nettype wire

@@ hw/rtl/aisa_mem.sv @@
// Word memory with one write port, one registered read port and a clearing pass after reset.
`default_nettype none

module aisa_mem #(
    parameter int MEM_WORDS = 4096
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          wr_en,
    input  wire logic [$clog2(MEM_WORDS)-1:0]  wr_addr,
    input  wire logic [aisa_pkg::DATA_W-1:0]   wr_data,
    input  wire logic                          rd_en,
    input  wire logic [$clog2(MEM_WORDS)-1:0]  rd_addr,
    output logic      [aisa_pkg::DATA_W-1:0]   rd_data,
    output logic                               busy
);

    localparam int AW = $clog2(MEM_WORDS);

    logic [aisa_pkg::DATA_W-1:0] mem_array [MEM_WORDS];
    logic [aisa_pkg::DATA_W-1:0] rd_data_reg;
    logic                        clr_active_reg;
    logic                        clr_active_next;
    logic [AW-1:0]               clr_idx_reg;
    logic [AW-1:0]               clr_idx_next;
    logic                        we;
    logic [AW-1:0]               wa;
    logic [aisa_pkg::DATA_W-1:0] wd;

    // The sweep writes zero to every word, one a cycle, before any item is taken.
    always_comb
    begin
        clr_active_next = clr_active_reg;
        clr_idx_next    = clr_idx_reg;
        if (clr_active_reg)
        begin
            clr_idx_next = clr_idx_reg + AW'(1);
            if (clr_idx_reg == AW'(MEM_WORDS - 1))
            begin
                clr_active_next = 1'b0;
            end
        end
    end

    always_comb
    begin
        if (clr_active_reg)
        begin
            we = 1'b1;
            wa = clr_idx_reg;
            wd = '0;
        end
        else
        begin
            we = wr_en;
            wa = wr_addr;
            wd = wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_active_reg <= 1'b1;
            clr_idx_reg    <= '0;
        end
        else
        begin
            clr_active_reg <= clr_active_next;
            clr_idx_reg    <= clr_idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_array[wa] <= wd;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem_array[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;
    assign busy    = clr_active_reg;

endmodule

`default_nettype wire

@@ hw/rtl/aisa_exec.sv @@
// Architectural registers and the instruction execute logic.
`default_nettype none

module aisa_exec #(
    parameter int MEM_WORDS = 4096
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire aisa_pkg::exec_ctl_t           ctl,
    input  wire logic [aisa_pkg::DATA_W-1:0]   instr,
    input  wire logic [aisa_pkg::DATA_W-1:0]   mem_word,
    output aisa_pkg::arch_t                    arch_next,
    output aisa_pkg::exec_info_t               info
);

    localparam logic [aisa_pkg::DATA_W-1:0] MemLimit = aisa_pkg::DATA_W'(MEM_WORDS);

    aisa_pkg::arch_t             arch_reg;
    logic                        run_reg;
    logic                        run_next;
    logic [2:0]                  status_next;

    logic [7:0]                  op;
    logic [aisa_pkg::DATA_W-1:0] operand;
    logic [aisa_pkg::DATA_W-1:0] pc_inc;
    logic [aisa_pkg::DATA_W-1:0] target;
    logic [aisa_pkg::DATA_W-1:0] ea;
    logic                        ea_ok;
    logic                        is_load;
    logic                        is_store;

    aisa_pkg::arch_t             ex_arch;
    logic                        ex_run;
    logic [2:0]                  ex_status;

    assign op       = instr[7:0];
    assign operand  = {{8{instr[31]}}, instr[31:8]};
    assign pc_inc   = arch_reg.pc + 32'd1;
    assign target   = pc_inc + operand;
    assign ea       = ((op == aisa_pkg::OP_LDL || op == aisa_pkg::OP_STL) ?
                       arch_reg.sp : arch_reg.a) + operand;
    assign ea_ok    = ea < MemLimit;
    assign is_load  = (op == aisa_pkg::OP_LDL) || (op == aisa_pkg::OP_LDNL);
    assign is_store = (op == aisa_pkg::OP_STL) || (op == aisa_pkg::OP_STNL);

    // Outcome of an instruction that needs no loaded word.
    always_comb
    begin
        ex_arch    = arch_reg;
        ex_arch.pc = pc_inc;
        ex_run     = run_reg;
        ex_status  = aisa_pkg::ST_OK;
        unique case (op)
            aisa_pkg::OP_LDC:
            begin
                ex_arch.b = arch_reg.a;
                ex_arch.a = operand;
            end
            aisa_pkg::OP_ADC:  ex_arch.a = arch_reg.a + operand;
            aisa_pkg::OP_LDL, aisa_pkg::OP_LDNL:
            begin
                // Only reached here with an address outside memory.
                ex_arch   = arch_reg;
                ex_run    = 1'b0;
                ex_status = aisa_pkg::ST_BADADDR;
            end
            aisa_pkg::OP_STL:
            begin
                if (ea_ok)
                begin
                    ex_arch.a = arch_reg.b;
                end
                else
                begin
                    ex_arch   = arch_reg;
                    ex_run    = 1'b0;
                    ex_status = aisa_pkg::ST_BADADDR;
                end
            end
            aisa_pkg::OP_STNL:
            begin
                if (!ea_ok)
                begin
                    ex_arch   = arch_reg;
                    ex_run    = 1'b0;
                    ex_status = aisa_pkg::ST_BADADDR;
                end
            end
            aisa_pkg::OP_ADD:  ex_arch.a = arch_reg.b + arch_reg.a;
            aisa_pkg::OP_SUB:  ex_arch.a = arch_reg.b - arch_reg.a;
            aisa_pkg::OP_SHL:
                ex_arch.a = (|arch_reg.a[31:5]) ? '0 : (arch_reg.b << arch_reg.a[4:0]);
            aisa_pkg::OP_SHR:
                ex_arch.a = (|arch_reg.a[31:5]) ? '0 : (arch_reg.b >> arch_reg.a[4:0]);
            aisa_pkg::OP_ADJ:  ex_arch.sp = arch_reg.sp + operand;
            aisa_pkg::OP_A2SP:
            begin
                ex_arch.sp = arch_reg.a;
                ex_arch.a  = arch_reg.b;
            end
            aisa_pkg::OP_SP2A:
            begin
                ex_arch.b = arch_reg.a;
                ex_arch.a = arch_reg.sp;
            end
            aisa_pkg::OP_CALL:
            begin
                ex_arch.b  = arch_reg.a;
                ex_arch.a  = pc_inc;
                ex_arch.pc = target;
            end
            aisa_pkg::OP_RET:
            begin
                ex_arch.pc = arch_reg.a;
                ex_arch.a  = arch_reg.b;
            end
            aisa_pkg::OP_BRZ:
                ex_arch.pc = (arch_reg.a == '0) ? target : pc_inc;
            aisa_pkg::OP_BRLZ:
                ex_arch.pc = arch_reg.a[31] ? target : pc_inc;
            aisa_pkg::OP_BR:   ex_arch.pc = target;
            aisa_pkg::OP_HALT:
            begin
                ex_run    = 1'b0;
                ex_status = aisa_pkg::ST_HALT;
            end
            default:
            begin
                ex_arch   = arch_reg;
                ex_run    = 1'b0;
                ex_status = aisa_pkg::ST_BADOP;
            end
        endcase
    end

    always_comb
    begin
        arch_next   = arch_reg;
        run_next    = run_reg;
        status_next = aisa_pkg::ST_OK;
        priority if (ctl.stop_pc)
        begin
            run_next    = 1'b0;
            status_next = aisa_pkg::ST_BADPC;
        end
        else if (ctl.commit_load)
        begin
            if (op == aisa_pkg::OP_LDL)
            begin
                arch_next.b = arch_reg.a;
            end
            arch_next.a  = mem_word;
            arch_next.pc = pc_inc;
        end
        else if (ctl.commit_exec)
        begin
            arch_next   = ex_arch;
            run_next    = ex_run;
            status_next = ex_status;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            arch_reg <= '0;
            run_reg  <= 1'b1;
        end
        else
        begin
            arch_reg <= arch_next;
            run_reg  <= run_next;
        end
    end

    always_comb
    begin
        info.running    = run_reg;
        info.pc_ok      = arch_reg.pc < MemLimit;
        info.is_load    = is_load;
        info.is_store   = is_store;
        info.ea_ok      = ea_ok;
        info.ea         = ea;
        info.opcode     = op;
        info.store_data = (op == aisa_pkg::OP_STL) ? arch_reg.a : arch_reg.b;
        info.status     = status_next;
    end

endmodule

`default_nettype wire

@@ hw/rtl/aisa_check.sv @@
// Port-level checks on the accumulator core, bound to the top level.
`default_nettype none

module aisa_check (
    input wire logic              clk,
    input wire logic              rst_n,
    input wire logic              item_valid,
    input wire logic              item_ready,
    input wire aisa_pkg::item_t   item,
    input wire logic              result_valid,
    input wire logic              result_ready,
    input wire aisa_pkg::result_t result
);

    // A word offered on the result side holds until it is taken.
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(result))
        else $error("result word changed or dropped while stalled");

    // No item is taken straight after reset, while the memory is being cleared.
    a_reset_refuse: assert property (@(posedge clk)
        !rst_n |=> !item_ready)
        else $error("item taken straight after reset");

    // Only a read item returns data, and reads always report success.
    a_error_no_data: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.status != aisa_pkg::ST_OK |-> result.read_data == '0)
        else $error("read data on a result with non-ok status");

    // No instruction is fetched when stopped or when the PC is outside memory.
    a_no_fetch_opcode: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid &&
        (result.status == aisa_pkg::ST_STOPPED || result.status == aisa_pkg::ST_BADPC)
        |-> result.executed_opcode == '0)
        else $error("opcode reported for an instruction that was not fetched");

    // A halt status comes only from the halt opcode.
    a_halt_opcode: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.status == aisa_pkg::ST_HALT
        |-> result.executed_opcode == aisa_pkg::OP_HALT)
        else $error("halt status without halt opcode");

endmodule

bind accumulator_isa_core aisa_check u_aisa_check (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
);

`default_nettype wire
